>>> rtl/pba_pkg.sv
// Shared types and constants of the page bitmap allocator.
`default_nettype none

package pba_pkg;

    // One bitmap word holds the used bits of this many pages.
    localparam int WORD_W = 32;
    localparam int WBIT_W = 5;

    // Byte offset bits of a 4 KiB page.
    localparam int PAGE_SHIFT = 12;

    // A 32-bit byte count rounds up to at most 2^20 pages, so page numbers and
    // run lengths of a request need 21 bits.
    localparam int REQ_W = 32 - PAGE_SHIFT + 1;
    localparam int RUN_W = REQ_W;

    // Request modes.
    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    // Outcome of searching one bitmap word for a free run.
    typedef struct packed {
        logic              found;
        logic [WBIT_W-1:0] bit_idx;
        logic [RUN_W-1:0]  run_out;
    } t_scan_res;

endpackage

`default_nettype wire

>>> rtl/pba_req_if.sv
// Request channel of the page bitmap allocator.
`default_nettype none

interface pba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] size_bytes;
    logic [31:0] byte_address;

    modport source (output valid, output mode, output size_bytes, output byte_address,
                    input ready);
    modport sink   (input valid, input mode, input size_bytes, input byte_address,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pba_rsp_if.sv
// Response channel of the page bitmap allocator.
`default_nettype none

interface pba_rsp_if #(
    parameter int ADDR_W = 24,
    parameter int CNT_W  = 13
);
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] page_address;
    logic              success;
    logic [CNT_W-1:0]  free_pages;

    modport source (output valid, output page_address, output success, output free_pages,
                    input ready);
    modport sink   (input valid, input page_address, input success, input free_pages,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pba_bitmap_ram.sv
// Simple dual-port bitmap RAM with a registered read.
`default_nettype none

module pba_bitmap_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/pba_range_mask.sv
// Mask of the pages of one bitmap word that fall inside a page range.
`default_nettype none

module pba_range_mask #(
    parameter int WADDR_W = 7
) (
    input  wire logic [WADDR_W-1:0]        i_word,
    input  wire logic [pba_pkg::REQ_W-1:0] i_lo,
    input  wire logic [pba_pkg::REQ_W-1:0] i_hi,
    output logic      [pba_pkg::WORD_W-1:0] o_mask
);

    logic [pba_pkg::REQ_W-1:0] base;

    assign base = pba_pkg::REQ_W'({i_word, {pba_pkg::WBIT_W{1'b0}}});

    // A bit is set when its page lies in [lo, hi).
    always_comb begin
        logic [pba_pkg::REQ_W-1:0] pg;
        o_mask = '0;
        pg     = '0;
        for (int b = 0; b < pba_pkg::WORD_W; b++) begin
            pg        = base + pba_pkg::REQ_W'(b);
            o_mask[b] = (pg >= i_lo) && (pg < i_hi);
        end
    end

endmodule

`default_nettype wire

>>> rtl/pba_run_finder.sv
// First-fit run search over one bitmap word, continuing a run from earlier words.
`default_nettype none

module pba_run_finder (
    input  wire logic [pba_pkg::WORD_W-1:0] i_used,
    input  wire logic [pba_pkg::RUN_W-1:0]  i_run_in,
    input  wire logic [pba_pkg::RUN_W-1:0]  i_npages,
    output pba_pkg::t_scan_res              o_res
);

    // The run length at each bit is worked out on its own: the distance from
    // the last used bit at or below it, or the carried run plus the bit count
    // when the word is free up to that bit.
    always_comb begin
        logic                       any_used;
        logic [pba_pkg::WBIT_W-1:0] last_used;
        logic [pba_pkg::RUN_W-1:0]  run;
        o_res     = '0;
        any_used  = 1'b0;
        last_used = '0;
        run       = '0;
        for (int b = 0; b < pba_pkg::WORD_W; b++) begin
            any_used  = 1'b0;
            last_used = '0;
            for (int j = 0; j <= b; j++) begin
                if (i_used[j]) begin
                    any_used  = 1'b1;
                    last_used = pba_pkg::WBIT_W'(j);
                end
            end
            if (any_used) begin
                run = pba_pkg::RUN_W'(b) - pba_pkg::RUN_W'(last_used);
            end else begin
                run = i_run_in + pba_pkg::RUN_W'(b + 1);
            end
            if (!o_res.found && !i_used[b] && (run == i_npages)) begin
                o_res.found   = 1'b1;
                o_res.bit_idx = pba_pkg::WBIT_W'(b);
            end
            if (b == pba_pkg::WORD_W - 1) begin
                o_res.run_out = run;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/page_bitmap_allocator.sv
// Top level of the first-fit page bitmap allocator.
//
// Channel   Dir  Handshake           Payload
// i_req     in   valid/ready         mode, size_bytes, byte_address
// o_rsp     out  valid/ready         page_address, success, free_pages
// cfg       in   i_cfg_we (no wait)  i_cfg_wdata = total_pages
//
// A query, a rejected request or a free that clears nothing goes from S_PREP
// straight to S_DONE and the output register. An allocation goes through
// S_PREP, a search in S_SCAN over up to ceil(total_pages/32) bitmap words,
// S_SETUP, a marking pass in S_MOD and S_DONE; the search rate is set by the
// single read port of the bitmap RAM, one 32-page word per cycle. A free goes
// through S_PREP, S_FCOUNT, a read-modify-write pass in S_MOD and S_DONE.
// Reset and every total_pages write start a clearing pass that rewrites all
// ceil(MAX_PAGES/32) bitmap words (128 at default); no request is taken meanwhile.
// A finished response waits in the output register while new requests are taken.
`default_nettype none

module page_bitmap_allocator #(
    parameter int  MAX_PAGES      = 4096,
    parameter int  RESERVED_PAGES = 1024,
    localparam int CNT_W          = $clog2(MAX_PAGES + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    pba_req_if.sink               i_req,
    pba_rsp_if.source             o_rsp,
    input  wire logic             i_cfg_we,
    input  wire logic [CNT_W-1:0] i_cfg_wdata
);

    localparam int WORD_W  = pba_pkg::WORD_W;
    localparam int WBIT_W  = pba_pkg::WBIT_W;
    localparam int REQ_W   = pba_pkg::REQ_W;
    localparam int RUN_W   = pba_pkg::RUN_W;
    localparam int NWORDS  = (MAX_PAGES + WORD_W - 1) / WORD_W;
    localparam int WADDR_W = $clog2(NWORDS);
    localparam int PAGE_W  = $clog2(MAX_PAGES);
    localparam int ADDR_W  = PAGE_W + pba_pkg::PAGE_SHIFT;
    localparam int FIRST_W = 32 - pba_pkg::PAGE_SHIFT;

    // Controller states.
    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_SETUP  = 3'd4;
    localparam logic [2:0] S_FCOUNT = 3'd5;
    localparam logic [2:0] S_MOD    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]         r_state,     n_state;
    logic [WADDR_W-1:0] r_rd_word,   n_rd_word;
    logic [WADDR_W-1:0] r_pw,        n_pw;
    logic               r_pv,        n_pv;
    logic [WADDR_W-1:0] r_last,      n_last;
    logic [RUN_W-1:0]   r_run,       n_run;
    logic [REQ_W-1:0]   r_lo,        n_lo;
    logic [REQ_W-1:0]   r_hi,        n_hi;
    logic               r_set,       n_set;
    logic [1:0]         r_mode,      n_mode;
    logic [REQ_W-1:0]   r_npages,    n_npages;
    logic [FIRST_W-1:0] r_first,     n_first;
    logic [CNT_W-1:0]   r_total,     n_total;
    logic [CNT_W-1:0]   r_free,      n_free;
    logic [ADDR_W-1:0]  r_res_addr,  n_res_addr;
    logic               r_res_ok,    n_res_ok;
    logic               r_out_valid, n_out_valid;
    logic [ADDR_W-1:0]  r_out_addr,  n_out_addr;
    logic               r_out_ok,    n_out_ok;
    logic [CNT_W-1:0]   r_out_free,  n_out_free;

    logic               ram_we;
    logic [WADDR_W-1:0] ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;

    logic [WADDR_W-1:0] m_word;
    logic [REQ_W-1:0]   m_lo;
    logic [REQ_W-1:0]   m_hi;
    logic [WORD_W-1:0]  m_bits;

    pba_pkg::t_scan_res scan;
    logic [WORD_W-1:0]  scan_used;

    logic [REQ_W-1:0]   total_x;
    logic [REQ_W-1:0]   total_m1;
    logic [REQ_W-1:0]   hi_m1;
    logic [REQ_W-1:0]   first_x;
    logic [REQ_W-1:0]   free_end;
    logic [REQ_W-1:0]   alloc_lo;
    logic [REQ_W-1:0]   cleared;
    logic [CNT_W:0]     free_sum;
    logic [CNT_W-1:0]   cfg_total;
    logic               req_ready;

    assign total_x   = REQ_W'(r_total);
    assign total_m1  = total_x - REQ_W'(1);
    assign hi_m1     = r_hi - REQ_W'(1);
    assign first_x   = REQ_W'(r_first);
    assign free_end  = first_x + r_npages;
    assign alloc_lo  = r_hi - r_npages;
    assign cleared   = r_hi - r_lo;
    assign free_sum  = {1'b0, r_free} + (CNT_W + 1)'(cleared);

    // Pages at or beyond the total look used to the search.
    assign scan_used = ram_rdata | ~m_bits;

    // A written total is clamped to RESERVED_PAGES at the least and MAX_PAGES at the most.
    always_comb begin
        if (i_cfg_wdata > CNT_W'(MAX_PAGES)) begin
            cfg_total = CNT_W'(MAX_PAGES);
        end else if (i_cfg_wdata < CNT_W'(RESERVED_PAGES)) begin
            cfg_total = CNT_W'(RESERVED_PAGES);
        end else begin
            cfg_total = i_cfg_wdata;
        end
    end

    // The one mask unit serves the clearing pass, the search and the
    // read-modify-write pass, each with its own page range.
    always_comb begin
        case (r_state)
            S_INIT: begin
                m_word = r_rd_word;
                m_lo   = '0;
                m_hi   = REQ_W'(RESERVED_PAGES);
            end
            S_SCAN: begin
                m_word = r_pw;
                m_lo   = '0;
                m_hi   = total_x;
            end
            default: begin
                m_word = r_pw;
                m_lo   = r_lo;
                m_hi   = r_hi;
            end
        endcase
    end

    pba_range_mask #(
        .WADDR_W (WADDR_W)
    ) u_mask (
        .i_word (m_word),
        .i_lo   (m_lo),
        .i_hi   (m_hi),
        .o_mask (m_bits)
    );

    pba_run_finder u_finder (
        .i_used   (scan_used),
        .i_run_in (r_run),
        .i_npages (r_npages),
        .o_res    (scan)
    );

    pba_bitmap_ram #(
        .DEPTH (NWORDS),
        .AW    (WADDR_W),
        .DW    (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_word),
        .o_rdata (ram_rdata)
    );

    // A configuration write in the same cycle takes precedence over a request.
    assign req_ready   = (r_state == S_IDLE) && !i_cfg_we;
    assign i_req.ready = req_ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.page_address = r_out_addr;
    assign o_rsp.success      = r_out_ok;
    assign o_rsp.free_pages   = r_out_free;

    always_comb begin
        n_state     = r_state;
        n_rd_word   = r_rd_word;
        n_pw        = r_pw;
        n_pv        = r_pv;
        n_last      = r_last;
        n_run       = r_run;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_set       = r_set;
        n_mode      = r_mode;
        n_npages    = r_npages;
        n_first     = r_first;
        n_total     = r_total;
        n_free      = r_free;
        n_res_addr  = r_res_addr;
        n_res_ok    = r_res_ok;
        n_out_valid = r_out_valid;
        n_out_addr  = r_out_addr;
        n_out_ok    = r_out_ok;
        n_out_free  = r_out_free;
        ram_we      = 1'b0;
        ram_waddr   = r_pw;
        ram_wdata   = r_set ? (ram_rdata | m_bits) : (ram_rdata & ~m_bits);

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                // Clearing pass: each word gets its reserved pages set.
                ram_we    = 1'b1;
                ram_waddr = r_rd_word;
                ram_wdata = m_bits;
                if (r_rd_word == WADDR_W'(NWORDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_rd_word = r_rd_word + WADDR_W'(1);
                end
            end
            S_IDLE: begin
                if (i_req.valid && req_ready) begin
                    n_mode   = i_req.mode;
                    n_first  = i_req.byte_address[31:pba_pkg::PAGE_SHIFT];
                    n_npages = REQ_W'(i_req.size_bytes[31:pba_pkg::PAGE_SHIFT])
                             + REQ_W'(|i_req.size_bytes[pba_pkg::PAGE_SHIFT-1:0]);
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                n_res_addr = '0;
                case (r_mode)
                    pba_pkg::MODE_ALLOC: begin
                        if ((r_npages == '0) || (r_npages > total_x)) begin
                            n_res_ok = 1'b0;
                            n_state  = S_DONE;
                        end else begin
                            n_rd_word = '0;
                            n_pv      = 1'b0;
                            n_run     = '0;
                            n_last    = total_m1[WADDR_W+WBIT_W-1:WBIT_W];
                            n_state   = S_SCAN;
                        end
                    end
                    pba_pkg::MODE_FREE: begin
                        n_res_ok = 1'b1;
                        if ((first_x >= total_x) || (r_npages == '0)) begin
                            // Nothing below the total to clear, or an empty range.
                            n_state = S_DONE;
                        end else begin
                            n_lo    = first_x;
                            n_hi    = (free_end > total_x) ? total_x : free_end;
                            n_state = S_FCOUNT;
                        end
                    end
                    pba_pkg::MODE_QUERY: begin
                        n_res_ok = 1'b1;
                        n_state  = S_DONE;
                    end
                    default: begin
                        n_res_ok = 1'b0;
                        n_state  = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                // Reads run one word ahead of the search.
                n_pv      = 1'b1;
                n_pw      = r_rd_word;
                n_rd_word = r_rd_word + WADDR_W'(1);
                if (r_pv) begin
                    if (scan.found) begin
                        n_hi    = REQ_W'({r_pw, scan.bit_idx}) + REQ_W'(1);
                        n_state = S_SETUP;
                    end else if (r_pw == r_last) begin
                        n_res_ok = 1'b0;
                        n_state  = S_DONE;
                    end else begin
                        n_run = scan.run_out;
                    end
                end
            end
            S_SETUP: begin
                n_lo       = alloc_lo;
                n_rd_word  = alloc_lo[WADDR_W+WBIT_W-1:WBIT_W];
                n_last     = hi_m1[WADDR_W+WBIT_W-1:WBIT_W];
                n_pv       = 1'b0;
                n_set      = 1'b1;
                n_free     = r_free - CNT_W'(r_npages);
                n_res_addr = {alloc_lo[PAGE_W-1:0], {pba_pkg::PAGE_SHIFT{1'b0}}};
                n_res_ok   = 1'b1;
                n_state    = S_MOD;
            end
            S_FCOUNT: begin
                // Cleared pages are counted whether or not they were in use.
                n_free    = (free_sum > {1'b0, r_total}) ? r_total : free_sum[CNT_W-1:0];
                n_rd_word = r_lo[WADDR_W+WBIT_W-1:WBIT_W];
                n_last    = hi_m1[WADDR_W+WBIT_W-1:WBIT_W];
                n_pv      = 1'b0;
                n_set     = 1'b0;
                n_state   = S_MOD;
            end
            S_MOD: begin
                // Each word is read once and written back the next cycle, so the
                // write never meets a read of the same word.
                n_pv      = 1'b1;
                n_pw      = r_rd_word;
                n_rd_word = r_rd_word + WADDR_W'(1);
                if (r_pv) begin
                    ram_we = 1'b1;
                    if (r_pw == r_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_out_addr  = r_res_addr;
                    n_out_ok    = r_res_ok;
                    n_out_free  = r_free;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A total write rebuilds the map from the start.
        if (i_cfg_we) begin
            n_total   = cfg_total;
            n_free    = cfg_total - CNT_W'(RESERVED_PAGES);
            n_rd_word = '0;
            n_state   = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_rd_word   <= '0;
            r_pv        <= 1'b0;
            r_total     <= CNT_W'(MAX_PAGES);
            r_free      <= CNT_W'(MAX_PAGES - RESERVED_PAGES);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_word   <= n_rd_word;
            r_pv        <= n_pv;
            r_total     <= n_total;
            r_free      <= n_free;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pw       <= n_pw;
        r_last     <= n_last;
        r_run      <= n_run;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_set      <= n_set;
        r_mode     <= n_mode;
        r_npages   <= n_npages;
        r_first    <= n_first;
        r_res_addr <= n_res_addr;
        r_res_ok   <= n_res_ok;
        r_out_addr <= n_out_addr;
        r_out_ok   <= n_out_ok;
        r_out_free <= n_out_free;
    end

endmodule

`default_nettype wire
